### hw/rtl/bellman_ford_path_tiebreak_unit_assert.svh
// Assertion macros shared by the path unit.
`ifndef BELLMAN_FORD_PATH_TIEBREAK_UNIT_ASSERT_SVH
`define BELLMAN_FORD_PATH_TIEBREAK_UNIT_ASSERT_SVH

// Same-cycle implication.
`define BFPT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BFPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/bfpt_pkg.sv
package bfpt_pkg;

   localparam int NODE_DEPTH = 64;
   localparam int NW         = 6;
   localparam int NCW        = 7;
   localparam int COORD_W    = 11;
   localparam int WGT_W      = 25;
   localparam int DIST_W     = 32;
   localparam int HOP_W      = 16;
   localparam int COST_W     = 30;
   localparam int ACC_W      = 32;
   localparam int ACT_W      = 3;
   localparam int REQ_W      = 40;
   localparam int RSP_W      = 40;

   localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd0;
   localparam logic [ACT_W-1:0] ACT_LOAD  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_COIN  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_EDGE  = 3'd3;
   localparam logic [ACT_W-1:0] ACT_SOLVE = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EDGE_RD,
      ST_EDGE_SQ,
      ST_EDGE_WR,
      ST_RX_EDGE,
      ST_RX_NODE,
      ST_RX_CALC,
      ST_RX_DECIDE,
      ST_WK_PUSH,
      ST_WK_PRED,
      ST_WK_SQ,
      ST_WK_ACC,
      ST_EM_RD,
      ST_EM_SEND,
      ST_LOOP_SEND
   } bfpt_state_type;

   typedef struct packed {
      logic ready;
      logic do_clear;
      logic do_load;
      logic do_coin;
      logic latch_req;
      logic solve_start;
      logic walk_addr;
      logic edge_wr;
      logic rx_step;
      logic wk_push;
      logic wk_acc;
      logic out_load;
      logic loop_load;
   } bfpt_cmd_type;

   typedef struct packed {
      logic relax_skip;
      logic edge_last;
      logic round_last;
      logic loop_hit;
      logic pred_none;
      logic emit_last;
      logic out_busy;
   } bfpt_status_type;

endpackage

### hw/rtl/bellman_ford_path_tiebreak_unit.sv
// Shortest-path unit with tie-breaking over a small loaded graph.
// req channel: one command per transfer (tuser selects clear, load node,
// mark coin, add edge or solve; tdata carries ids and coordinates).
// rsp channel: one transfer per path node, source first, each with the total
// cost; tlast marks the final node, tuser flags a predecessor loop.
// csr_we/csr_wdata write the node count; write it only while idle.
// Clear, load node and mark coin finish without leaving idle; add edge keeps
// the unit busy through node read, squaring and table write.
// Solve runs node_count-1 rounds over the edge table, each edge passing
// through a read, add, compare and write-back in the distance store, then
// walks the predecessors node by node and emits one result per path node.
// One command is processed at a time; req_tready is high only when idle.
// Reset clears the node count to 1, empties the edge table and coin marks,
// and drops any pending result. A stalled receiver holds the current result
// in the output register and pauses the unit until it is taken.
module bellman_ford_path_tiebreak_unit import bfpt_pkg::*; #(
   parameter int MAX_EDGES = 512
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // node_id, target_id, x_coord, y_coord
   input  logic [ACT_W-1:0] req_tuser,   // action
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // path_node, path_cost
   output logic             rsp_tlast,
   output logic             rsp_tuser,   // loop_found
   input  logic             csr_we,
   input  logic [NCW-1:0]   csr_wdata
);

   bfpt_cmd_type    cmd;
   bfpt_status_type status;

   bfpt_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   bfpt_datapath #(
      .MAX_EDGES (MAX_EDGES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   assign req_tready = cmd.ready;

`include "bellman_ford_path_tiebreak_unit_assert.svh"

`BFPT_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.out_load || cmd.loop_load, !(rsp_tvalid && !rsp_tready), "result overwritten while stalled")
`BFPT_ASSERT_NOW(a_loop_single, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast, "loop result not final")
`BFPT_ASSERT_NOW(a_idle_quiet, clock, reset, req_tready, !cmd.rx_step && !cmd.wk_push && !cmd.edge_wr, "busy command while ready")
`BFPT_ASSERT_NEXT(a_solve_busy, clock, reset, req_tvalid && req_tready && (req_tuser == ACT_SOLVE), !req_tready, "solve did not leave idle")

endmodule

### hw/rtl/bfpt_controller.sv
module bfpt_controller import bfpt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic [ACT_W-1:0] req_tuser,
   input  bfpt_status_type  status,
   output bfpt_cmd_type     cmd
);

   bfpt_state_type state_ff, state_in;
   logic           accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign accept = req_tvalid && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.ready = 1'b1;
            if (accept) begin
               unique case (req_tuser)
                  ACT_CLEAR: cmd.do_clear = 1'b1;
                  ACT_LOAD:  cmd.do_load  = 1'b1;
                  ACT_COIN:  cmd.do_coin  = 1'b1;
                  ACT_EDGE: begin
                     cmd.latch_req = 1'b1;
                     state_in      = ST_EDGE_RD;
                  end
                  ACT_SOLVE: begin
                     cmd.solve_start = 1'b1;
                     state_in        = status.relax_skip ? ST_WK_PUSH : ST_RX_EDGE;
                  end
                  default: ;
               endcase
            end
         end
         ST_EDGE_RD: state_in = ST_EDGE_SQ;
         ST_EDGE_SQ: state_in = ST_EDGE_WR;
         ST_EDGE_WR: begin
            cmd.edge_wr = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_RX_EDGE: state_in = ST_RX_NODE;
         ST_RX_NODE: state_in = ST_RX_CALC;
         ST_RX_CALC: state_in = ST_RX_DECIDE;
         ST_RX_DECIDE: begin
            cmd.rx_step = 1'b1;
            state_in    = (status.edge_last && status.round_last) ? ST_WK_PUSH : ST_RX_EDGE;
         end
         ST_WK_PUSH: begin
            cmd.walk_addr = 1'b1;
            if (status.loop_hit) begin
               state_in = ST_LOOP_SEND;
            end else begin
               cmd.wk_push = 1'b1;
               state_in    = ST_WK_PRED;
            end
         end
         ST_WK_PRED: begin
            cmd.walk_addr = 1'b1;
            state_in      = status.pred_none ? ST_EM_RD : ST_WK_SQ;
         end
         ST_WK_SQ: begin
            cmd.walk_addr = 1'b1;
            state_in      = ST_WK_ACC;
         end
         ST_WK_ACC: begin
            cmd.walk_addr = 1'b1;
            cmd.wk_acc    = 1'b1;
            state_in      = ST_WK_PUSH;
         end
         ST_EM_RD: state_in = ST_EM_SEND;
         ST_EM_SEND: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = status.emit_last ? ST_IDLE : ST_EM_RD;
            end
         end
         ST_LOOP_SEND: begin
            if (!status.out_busy) begin
               cmd.loop_load = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

### hw/rtl/bfpt_datapath.sv
module bfpt_datapath import bfpt_pkg::*; #(
   parameter int MAX_EDGES = 512
) (
   input  logic             clock,
   input  logic             reset,
   input  bfpt_cmd_type     cmd,
   input  logic             csr_we,
   input  logic [NCW-1:0]   csr_wdata,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             rsp_tready,
   output bfpt_status_type  status,
   output logic             rsp_tvalid,
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tlast,
   output logic             rsp_tuser
);

   localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

   // request fields
   logic [NW-1:0]             f_node, f_tgt;
   logic signed [COORD_W-1:0] f_x, f_y;

   assign f_node = req_tdata[NW-1:0];
   assign f_tgt  = req_tdata[2*NW-1:NW];
   assign f_x    = req_tdata[2*NW+COORD_W-1:2*NW];
   assign f_y    = req_tdata[2*NW+2*COORD_W-1:2*NW+COORD_W];

   // node count register
   logic [NCW-1:0] ncount_ff, n_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ncount_ff <= NCW'(1);
      end else if (csr_we) begin
         ncount_ff <= csr_wdata;
      end
   end

   always_comb begin
      priority if (ncount_ff == '0) begin
         n_eff = NCW'(1);
      end else if (ncount_ff > NCW'(NODE_DEPTH)) begin
         n_eff = NCW'(NODE_DEPTH);
      end else begin
         n_eff = ncount_ff;
      end
   end

   // node store
   logic signed [COORD_W-1:0] x_mem [NODE_DEPTH];
   logic signed [COORD_W-1:0] y_mem [NODE_DEPTH];
   logic [NODE_DEPTH-1:0]     node_ok_ff, coin_ff;
   logic [NW-1:0]             a_ff, b_ff, na, nb;
   logic signed [COORD_W-1:0] xa_ff, ya_ff, xb_ff, yb_ff;
   logic                      oka_ff, okb_ff, coinb_ff, coin_sq_ff;
   logic signed [COORD_W-1:0] xa_e, ya_e, xb_e, yb_e;
   logic signed [COORD_W:0]   dx, dy;
   logic signed [2*COORD_W+1:0] sqx_ff, sqy_ff;
   logic signed [WGT_W-1:0]   sq_sum, weight;

   // distance store t side registered predecessor output, and the walk cursor
   logic [NW-1:0] pt_ff, cur_ff;

   assign na = cmd.walk_addr ? pt_ff : a_ff;
   assign nb = cmd.walk_addr ? cur_ff : b_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         a_ff <= f_node;
         b_ff <= f_tgt;
      end
      if (cmd.do_load) begin
         x_mem[f_node] <= f_x;
         y_mem[f_node] <= f_y;
      end
      xa_ff      <= x_mem[na];
      ya_ff      <= y_mem[na];
      xb_ff      <= x_mem[nb];
      yb_ff      <= y_mem[nb];
      oka_ff     <= node_ok_ff[na];
      okb_ff     <= node_ok_ff[nb];
      coinb_ff   <= coin_ff[nb];
      sqx_ff     <= dx * dx;
      sqy_ff     <= dy * dy;
      coin_sq_ff <= coinb_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.do_clear) begin
         node_ok_ff <= '0;
         coin_ff    <= '0;
      end else if (cmd.do_load) begin
         node_ok_ff[f_node] <= 1'b1;
         coin_ff[f_node]    <= 1'b0;
      end else if (cmd.do_coin) begin
         coin_ff[f_node] <= 1'b1;
      end
   end

   assign xa_e   = oka_ff ? xa_ff : '0;
   assign ya_e   = oka_ff ? ya_ff : '0;
   assign xb_e   = okb_ff ? xb_ff : '0;
   assign yb_e   = okb_ff ? yb_ff : '0;
   assign dx     = (COORD_W+1)'(xb_e) - (COORD_W+1)'(xa_e);
   assign dy     = (COORD_W+1)'(yb_e) - (COORD_W+1)'(ya_e);
   assign sq_sum = WGT_W'(sqx_ff) + WGT_W'(sqy_ff);
   assign weight = coin_sq_ff ? -sq_sum : sq_sum;

   // edge store
   logic [NW-1:0]           src_mem [MAX_EDGES];
   logic [NW-1:0]           tgt_mem [MAX_EDGES];
   logic signed [WGT_W-1:0] wgt_mem [MAX_EDGES];
   logic [EW:0]             edge_total_ff;
   logic [EW-1:0]           e_ff;
   logic [NW-1:0]           es_ff, et_ff;
   logic signed [WGT_W-1:0] ew_ff;

   always_ff @(posedge clock) begin
      if (cmd.edge_wr && (edge_total_ff < (EW+1)'(MAX_EDGES))) begin
         src_mem[edge_total_ff[EW-1:0]] <= a_ff;
         tgt_mem[edge_total_ff[EW-1:0]] <= b_ff;
         wgt_mem[edge_total_ff[EW-1:0]] <= weight;
      end
      es_ff <= src_mem[e_ff];
      et_ff <= tgt_mem[e_ff];
      ew_ff <= wgt_mem[e_ff];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.do_clear) begin
         edge_total_ff <= '0;
      end else if (cmd.edge_wr && (edge_total_ff < (EW+1)'(MAX_EDGES))) begin
         edge_total_ff <= edge_total_ff + 1'b1;
      end
   end

   // distance store
   logic signed [DIST_W-1:0] dist_mem [NODE_DEPTH];
   logic [HOP_W-1:0]         hop_mem [NODE_DEPTH];
   logic [NW-1:0]            pred_mem [NODE_DEPTH];
   logic                     pnone_mem [NODE_DEPTH];
   logic [NODE_DEPTH-1:0]    reach_ff;
   logic                     init0_ff;
   logic [NW-1:0]            ta, sa_ff, ta_ff;
   logic signed [DIST_W-1:0] ds_ff, dt_ff;
   logic [HOP_W-1:0]         hs_ff, ht_ff;
   logic                     pnt_ff;

   assign ta = cmd.walk_addr ? cur_ff : et_ff;

   logic                     s_init, t_init, s_reached, t_reached, pnone_t;
   logic signed [DIST_W-1:0] s_dist, t_dist;
   logic [HOP_W-1:0]         s_hop, t_hop;
   logic signed [DIST_W:0]   sum_w;
   logic signed [DIST_W-1:0] cand_ff, cand_in;
   logic [HOP_W-1:0]         hopc_ff;
   logic                     elig_ff, take;

   assign s_init    = (sa_ff == '0) && init0_ff;
   assign t_init    = (ta_ff == '0) && init0_ff;
   assign s_reached = s_init || reach_ff[sa_ff];
   assign t_reached = t_init || reach_ff[ta_ff];
   assign s_dist    = s_init ? '0 : ds_ff;
   assign t_dist    = t_init ? '0 : dt_ff;
   assign s_hop     = s_init ? '0 : hs_ff;
   assign t_hop     = t_init ? '0 : ht_ff;
   assign pnone_t   = t_init || !reach_ff[ta_ff] || pnt_ff;
   assign sum_w     = (DIST_W+1)'(s_dist) + (DIST_W+1)'(ew_ff);

   always_comb begin
      priority if (sum_w > (DIST_W+1)'(33'sh0_7FFF_FFFF)) begin
         cand_in = {1'b0, {(DIST_W-1){1'b1}}};
      end else if (sum_w < -(DIST_W+1)'(33'sh0_8000_0000)) begin
         cand_in = {1'b1, {(DIST_W-1){1'b0}}};
      end else begin
         cand_in = sum_w[DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rx_step && take) begin
         dist_mem[et_ff]  <= cand_ff;
         hop_mem[et_ff]   <= hopc_ff;
         pred_mem[et_ff]  <= es_ff;
         pnone_mem[et_ff] <= 1'b0;
      end
      sa_ff   <= es_ff;
      ta_ff   <= ta;
      ds_ff   <= dist_mem[es_ff];
      hs_ff   <= hop_mem[es_ff];
      dt_ff   <= dist_mem[ta];
      ht_ff   <= hop_mem[ta];
      pt_ff   <= pred_mem[ta];
      pnt_ff  <= pnone_mem[ta];
      cand_ff <= cand_in;
      hopc_ff <= (s_hop == '1) ? s_hop : s_hop + 1'b1;
      elig_ff <= ({1'b0, es_ff} < n_eff) && ({1'b0, et_ff} < n_eff) && s_reached;
   end

   assign take = elig_ff && (!t_reached || (cand_ff < t_dist) ||
                 ((cand_ff == t_dist) && ((hopc_ff < t_hop) ||
                 ((hopc_ff == t_hop) && !pnone_t && (es_ff < pt_ff)))));

   // round and edge counters
   logic [NCW-1:0] r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         reach_ff <= '0;
         init0_ff <= 1'b0;
      end else if (cmd.solve_start) begin
         reach_ff <= '0;
         init0_ff <= 1'b1;
      end else if (cmd.rx_step && take) begin
         reach_ff[et_ff] <= 1'b1;
         if (et_ff == '0) begin
            init0_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.solve_start) begin
         e_ff <= '0;
         r_ff <= '0;
      end else if (cmd.rx_step) begin
         if (status.edge_last) begin
            e_ff <= '0;
            r_ff <= r_ff + 1'b1;
         end else begin
            e_ff <= e_ff + 1'b1;
         end
      end
   end

   // predecessor walk and path stack
   logic [NW-1:0]           stack_mem [NODE_DEPTH];
   logic [NW-1:0]           stack_rd_ff;
   logic [NCW-1:0]          count_ff, count_m1;
   logic signed [ACC_W-1:0] cost_ff;
   logic signed [COST_W-1:0] cost_sat;

   assign count_m1 = count_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.wk_push) begin
         stack_mem[count_ff[NW-1:0]] <= cur_ff;
      end
      stack_rd_ff <= stack_mem[count_m1[NW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.solve_start) begin
         cur_ff   <= NW'(n_eff - 1'b1);
         count_ff <= '0;
         cost_ff  <= '0;
      end else begin
         if (cmd.wk_push) begin
            count_ff <= count_ff + 1'b1;
         end else if (cmd.out_load) begin
            count_ff <= count_m1;
         end
         if (cmd.wk_acc) begin
            cost_ff <= cost_ff + ACC_W'(weight);
            cur_ff  <= pt_ff;
         end
      end
   end

   always_comb begin
      priority if (cost_ff > ACC_W'(32'sd536870911)) begin
         cost_sat = {1'b0, {(COST_W-1){1'b1}}};
      end else if (cost_ff < -ACC_W'(32'sd536870912)) begin
         cost_sat = {1'b1, {(COST_W-1){1'b0}}};
      end else begin
         cost_sat = cost_ff[COST_W-1:0];
      end
   end

   // output register
   logic                     rsp_valid_ff, rsp_last_ff, rsp_loop_ff;
   logic [NW-1:0]            rsp_node_ff;
   logic signed [COST_W-1:0] rsp_cost_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load || cmd.loop_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_node_ff <= stack_rd_ff;
         rsp_cost_ff <= cost_sat;
         rsp_last_ff <= (count_ff == NCW'(1));
         rsp_loop_ff <= 1'b0;
      end else if (cmd.loop_load) begin
         rsp_node_ff <= '0;
         rsp_cost_ff <= '0;
         rsp_last_ff <= 1'b1;
         rsp_loop_ff <= 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-NW-COST_W){1'b0}}, rsp_cost_ff, rsp_node_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_loop_ff;

   assign status.relax_skip = (n_eff < NCW'(2)) || (edge_total_ff == '0);
   assign status.edge_last  = ((EW+1)'(e_ff) + 1'b1) == edge_total_ff;
   assign status.round_last = (r_ff + NCW'(2)) == n_eff;
   assign status.loop_hit   = count_ff >= n_eff;
   assign status.pred_none  = pnone_t;
   assign status.emit_last  = (count_ff == NCW'(1));
   assign status.out_busy   = rsp_valid_ff && !rsp_tready;

endmodule
